// ===== hw/rtl/lbs_pkg.sv =====
// Shared types and constants of the vertex skinning block.
package lbs_pkg;

  localparam int BONES_DEF   = 256;
  localparam int INFL_DEF    = 4;
  localparam int CARRIED     = 4;
  localparam int SLOTS       = 12;

  localparam int POS_W       = 32;
  localparam int NRM_W       = 16;
  localparam int WGT_W       = 16;
  localparam int ID_W        = 8;
  localparam int SLOT_W      = 4;
  localparam int PP_W        = 64;
  localparam int NP_W        = 48;
  localparam int PSUM_W      = 66;
  localparam int NSUM_W      = 50;
  localparam int T_W         = PSUM_W - 16;
  localparam int U_W         = NSUM_W - 16;
  localparam int TW_W        = T_W + WGT_W;
  localparam int UW_W        = U_W + WGT_W;
  localparam int ACC_P_W     = TW_W - 15 + 2;
  localparam int ACC_N_W     = UW_W - 15 + 2;

  typedef enum logic {
    CMD_SKIN = 1'b0,
    CMD_LOAD = 1'b1
  } lbs_cmd_t;

  // Per-stage advance strobes of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } lbs_adv_t;

  // Palette element write request.
  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   bone;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  value;
  } lbs_wr_t;

endpackage

// ===== hw/rtl/lbs_if.sv =====
// Handshake interfaces of the vertex request and result channels.
interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] nrm_x;
  logic signed [15:0] nrm_y;
  logic signed [15:0] nrm_z;
  logic [31:0]        bone_ids;
  logic [63:0]        blend_weights;
  logic [7:0]         entry_bone;
  logic [3:0]         entry_slot;
  logic signed [31:0] entry_value;

  modport source (output valid, command, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  bone_ids, blend_weights, entry_bone, entry_slot, entry_value,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                bone_ids, blend_weights, entry_bone, entry_slot, entry_value,
                output ready);
endinterface

interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [15:0] out_nrm_x;
  logic signed [15:0] out_nrm_y;
  logic signed [15:0] out_nrm_z;
  logic               passed_through;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, passed_through, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                out_nrm_z, passed_through, output ready);
endinterface

// ===== hw/rtl/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lbs_lane.sv =====
// One influence lane: palette copy, matrix transform and weight multiply.
module lbs_lane import lbs_pkg::*; #(
  parameter int BONES = BONES_DEF
) (
  input  logic                    clk,
  input  lbs_adv_t                adv,
  input  lbs_wr_t                 wr,
  input  logic [ID_W-1:0]         rd_bone,
  input  logic signed [POS_W-1:0] pos [3],
  input  logic signed [NRM_W-1:0] nrm [3],
  input  logic signed [WGT_W-1:0] wgt,
  output logic signed [TW_W-1:0]  tw [3],
  output logic signed [UW_W-1:0]  uw [3]
);

  localparam int AW = BONES > 1 ? $clog2(BONES) : 1;

  logic [POS_W-1:0]        m [SLOTS];
  logic signed [PP_W-1:0]  pp_r [3][3];
  logic signed [NP_W-1:0]  np_r [3][3];
  logic signed [POS_W-1:0] m3_r [3];
  logic signed [T_W-1:0]   t_r [3];
  logic signed [U_W-1:0]   u_r [3];
  logic signed [TW_W-1:0]  tw_r [3];
  logic signed [UW_W-1:0]  uw_r [3];

  // Every matrix element has its own RAM so all twelve are read at once.
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    lbs_ram #(.WIDTH(POS_W), .DEPTH(BONES)) u_ram (
      .clk  (clk),
      .we   (wr.en && (wr.slot == SLOT_W'(s))),
      .waddr(wr.bone[AW-1:0]),
      .wdata(wr.value),
      .re   (adv.s1),
      .raddr(rd_bone[AW-1:0]),
      .rdata(m[s])
    );
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (adv.s2) begin
        for (int r = 0; r < 3; r++) begin
          pp_r[c][r] <= PP_W'(pos[r]) * PP_W'($signed(m[r*3+c]));
          np_r[c][r] <= NP_W'(nrm[r]) * NP_W'($signed(m[r*3+c]));
        end
        m3_r[c] <= $signed(m[9+c]);
      end
      if (adv.s3) begin
        // Exact sum, plus translation for the position, then round half up by 16 bits.
        t_r[c] <= T_W'((PSUM_W'(pp_r[c][0]) + PSUM_W'(pp_r[c][1]) + PSUM_W'(pp_r[c][2])
                       + (PSUM_W'(m3_r[c]) <<< 16) + PSUM_W'(32768)) >>> 16);
        u_r[c] <= U_W'((NSUM_W'(np_r[c][0]) + NSUM_W'(np_r[c][1]) + NSUM_W'(np_r[c][2])
                       + NSUM_W'(32768)) >>> 16);
      end
      if (adv.s4) begin
        tw_r[c] <= TW_W'(t_r[c]) * TW_W'(wgt);
        uw_r[c] <= UW_W'(u_r[c]) * UW_W'(wgt);
      end
    end
  end

  assign tw = tw_r;
  assign uw = uw_r;

endmodule

// ===== hw/rtl/linear_blend_vertex_skinning.sv =====
// Linear blend vertex skinning with up to four bone influences per vertex.
// The block accepts one request per cycle, a palette load or a vertex, unless the
// result side stalls it. A vertex moves in turn through the registered palette read,
// transform multiply, row sum with rounding, weight multiply, and the blend sum
// with saturation into the output register. Each influence owns a full copy of
// the palette, one RAM per matrix element, so all twelve elements of each influence
// are read in the accept cycle; a load is visible to every vertex taken after it. The
// palette is not cleared at reset and a bone must be loaded before use.
module linear_blend_vertex_skinning import lbs_pkg::*; #(
  parameter int BONES      = BONES_DEF,
  parameter int INFLUENCES = INFL_DEF
) (
  input logic  clk,
  input logic  rst_n,
  lbs_in_if.sink    in_req,
  lbs_out_if.source out_res
);

  localparam int LANES = INFLUENCES < CARRIED ? INFLUENCES : CARRIED;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  logic acc_in;
  lbs_adv_t adv;
  lbs_wr_t  wr;

  logic signed [WGT_W-1:0] w0 [LANES];
  logic [ID_W-1:0]         b0 [LANES];
  logic [LANES-1:0]        act0;
  logic                    pt0;

  logic pt1_r, pt2_r, pt3_r, pt4_r;
  logic [LANES-1:0] act1_r, act2_r, act3_r, act4_r;
  logic signed [POS_W-1:0] pos1_r [3], pos2_r [3], pos3_r [3], pos4_r [3];
  logic signed [NRM_W-1:0] nrm1_r [3], nrm2_r [3], nrm3_r [3], nrm4_r [3];
  logic signed [WGT_W-1:0] w1_r [LANES], w2_r [LANES], w3_r [LANES];

  logic signed [TW_W-1:0] tw [LANES][3];
  logic signed [UW_W-1:0] uw [LANES][3];

  logic signed [POS_W-1:0] opos_r [3], opos_nxt [3];
  logic signed [NRM_W-1:0] onrm_r [3], onrm_nxt [3];
  logic                    opt_r;

  // Each stage moves on when it is empty or its successor moves on.
  assign en5 = !v5_r || out_res.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_req.ready = en1;
  assign acc_in = in_req.valid && en1;

  assign adv = '{s1: en1, s2: en2, s3: en3, s4: en4};

  assign wr.en = acc_in && (in_req.command == CMD_LOAD)
                 && ({1'b0, in_req.entry_bone} < 9'(BONES));
  assign wr.bone  = in_req.entry_bone;
  assign wr.slot  = in_req.entry_slot;
  assign wr.value = in_req.entry_value;

  // An influence counts while every weight up to it is positive and its bone exists.
  always_comb begin
    logic run;
    run = 1'b1;
    for (int n = 0; n < LANES; n++) begin
      w0[n]   = $signed(in_req.blend_weights[n*WGT_W +: WGT_W]);
      b0[n]   = in_req.bone_ids[n*ID_W +: ID_W];
      run     = run && !w0[n][WGT_W-1] && (w0[n] != '0);
      act0[n] = run && ({1'b0, b0[n]} < 9'(BONES));
    end
    pt0 = w0[0][WGT_W-1] || (w0[0] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_req.valid && (in_req.command == CMD_SKIN);
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pt1_r     <= pt0;
      act1_r    <= act0;
      pos1_r[0] <= in_req.pos_x;
      pos1_r[1] <= in_req.pos_y;
      pos1_r[2] <= in_req.pos_z;
      nrm1_r[0] <= in_req.nrm_x;
      nrm1_r[1] <= in_req.nrm_y;
      nrm1_r[2] <= in_req.nrm_z;
      w1_r      <= w0;
    end
    if (en2) begin
      pt2_r  <= pt1_r;
      act2_r <= act1_r;
      pos2_r <= pos1_r;
      nrm2_r <= nrm1_r;
      w2_r   <= w1_r;
    end
    if (en3) begin
      pt3_r  <= pt2_r;
      act3_r <= act2_r;
      pos3_r <= pos2_r;
      nrm3_r <= nrm2_r;
      w3_r   <= w2_r;
    end
    if (en4) begin
      pt4_r  <= pt3_r;
      act4_r <= act3_r;
      pos4_r <= pos3_r;
      nrm4_r <= nrm3_r;
    end
    if (en5) begin
      opt_r  <= pt4_r;
      opos_r <= opos_nxt;
      onrm_r <= onrm_nxt;
    end
  end

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    lbs_lane #(.BONES(BONES)) u_lane (
      .clk    (clk),
      .adv    (adv),
      .wr     (wr),
      .rd_bone(b0[n]),
      .pos    (pos1_r),
      .nrm    (nrm1_r),
      .wgt    (w3_r[n]),
      .tw     (tw[n]),
      .uw     (uw[n])
    );
  end

  // Round each weighted term by 15 bits, sum and saturate, or pass through.
  always_comb begin
    logic signed [ACC_P_W-1:0] acc_p;
    logic signed [ACC_N_W-1:0] acc_n;
    logic signed [TW_W-1:0]    rp;
    logic signed [UW_W-1:0]    rn;
    for (int c = 0; c < 3; c++) begin
      acc_p = '0;
      acc_n = '0;
      for (int n = 0; n < LANES; n++) begin
        rp = tw[n][c] + TW_W'(16384);
        rn = uw[n][c] + UW_W'(16384);
        if (act4_r[n]) begin
          acc_p = acc_p + ACC_P_W'($signed(rp[TW_W-1:15]));
          acc_n = acc_n + ACC_N_W'($signed(rn[UW_W-1:15]));
        end
      end
      if (pt4_r) begin
        opos_nxt[c] = pos4_r[c];
      end else if (acc_p != ACC_P_W'($signed(acc_p[POS_W-1:0]))) begin
        opos_nxt[c] = acc_p[ACC_P_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        opos_nxt[c] = acc_p[POS_W-1:0];
      end
      if (pt4_r) begin
        onrm_nxt[c] = nrm4_r[c];
      end else if (acc_n != ACC_N_W'($signed(acc_n[NRM_W-1:0]))) begin
        onrm_nxt[c] = acc_n[ACC_N_W-1] ? {1'b1, {(NRM_W-1){1'b0}}} : {1'b0, {(NRM_W-1){1'b1}}};
      end else begin
        onrm_nxt[c] = acc_n[NRM_W-1:0];
      end
    end
  end

  assign out_res.valid          = v5_r;
  assign out_res.out_pos_x      = opos_r[0];
  assign out_res.out_pos_y      = opos_r[1];
  assign out_res.out_pos_z      = opos_r[2];
  assign out_res.out_nrm_x      = onrm_r[0];
  assign out_res.out_nrm_y      = onrm_r[1];
  assign out_res.out_nrm_z      = onrm_r[2];
  assign out_res.passed_through = opt_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_req.ready) else $error("request refused with empty first stage");

  a_pass_no_blend: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && pt4_r |-> act4_r == '0) else $error("pass-through vertex has active influence");

  a_first_weight: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !pt1_r |-> !w1_r[0][WGT_W-1] && (w1_r[0] != '0))
    else $error("skinned vertex with non-positive first weight");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready && (in_req.command == CMD_LOAD) |=> !v1_r)
    else $error("palette load entered the pipeline");
`endif

endmodule

// ===== tb/lbs_skin_checker.sv =====
`timescale 1ns / 100ps
// Checker that watches the vertex request and result channels and compares each result.
module lbs_skin_checker import lbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lbs_in_if    in_mon,
  lbs_out_if   out_mon,
  output int   errors,
  output int   pending,
  output int   vertex_count,
  output int   copy_count,
  output int   load_count
);

  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] nrm_x, nrm_y, nrm_z;
    logic               passed_through;
  } skinned_vertex_t;

  logic [31:0]     palette [BONES_DEF][SLOTS];
  skinned_vertex_t skinned_q[$];

  function automatic logic signed [31:0] clamp_pos(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] clamp_nrm(input logic signed [95:0] v);
    if (v > 96'sd32767) return 16'sh7fff;
    if (v < -96'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Blends the transformed vertex over the leading positive weights with valid bones.
  function automatic skinned_vertex_t blend_vertex();
    skinned_vertex_t    r;
    logic signed [95:0] px[3], nx[3], acc_p[3], acc_n[3];
    logic signed [95:0] sp, sn, mv, t, u, w;
    int                 b;
    px[0] = 96'(in_mon.pos_x);  px[1] = 96'(in_mon.pos_y);  px[2] = 96'(in_mon.pos_z);
    nx[0] = 96'(in_mon.nrm_x);  nx[1] = 96'(in_mon.nrm_y);  nx[2] = 96'(in_mon.nrm_z);
    if ($signed(in_mon.blend_weights[15:0]) <= 16'sd0) begin
      r.pos_x = in_mon.pos_x;  r.pos_y = in_mon.pos_y;  r.pos_z = in_mon.pos_z;
      r.nrm_x = in_mon.nrm_x;  r.nrm_y = in_mon.nrm_y;  r.nrm_z = in_mon.nrm_z;
      r.passed_through = 1'b1;
      return r;
    end
    for (int c = 0; c < 3; c++) begin
      acc_p[c] = '0;
      acc_n[c] = '0;
    end
    for (int n = 0; n < CARRIED && n < INFL_DEF; n++) begin
      w = 96'($signed(in_mon.blend_weights[16*n +: 16]));
      if (w <= 96'sd0) break;
      b = int'(in_mon.bone_ids[8*n +: 8]);
      if (b >= BONES_DEF) continue;
      for (int c = 0; c < 3; c++) begin
        sp = '0;
        sn = '0;
        for (int rr = 0; rr < 3; rr++) begin
          mv = 96'($signed(palette[b][rr*3+c]));
          sp += px[rr] * mv;
          sn += nx[rr] * mv;
        end
        mv = 96'($signed(palette[b][9+c]));
        sp += mv <<< 16;
        t = (sp + 96'sd32768) >>> 16;
        u = (sn + 96'sd32768) >>> 16;
        acc_p[c] += (t * w + 96'sd16384) >>> 15;
        acc_n[c] += (u * w + 96'sd16384) >>> 15;
      end
    end
    r.pos_x = clamp_pos(acc_p[0]);  r.pos_y = clamp_pos(acc_p[1]);
    r.pos_z = clamp_pos(acc_p[2]);
    r.nrm_x = clamp_nrm(acc_n[0]);  r.nrm_y = clamp_nrm(acc_n[1]);
    r.nrm_z = clamp_nrm(acc_n[2]);
    r.passed_through = 1'b0;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    vertex_count = 0;
    copy_count = 0;
    load_count = 0;
    for (int b = 0; b < BONES_DEF; b++)
      for (int s = 0; s < SLOTS; s++) palette[b][s] = '0;
  end

  always @(posedge clk) begin
    skinned_vertex_t got, want;
    if (rst_n) begin
      // Compare first so a result never meets the request of the same edge.
      if (out_mon.valid && out_mon.ready) begin
        got.pos_x = out_mon.out_pos_x;  got.pos_y = out_mon.out_pos_y;
        got.pos_z = out_mon.out_pos_z;  got.nrm_x = out_mon.out_nrm_x;
        got.nrm_y = out_mon.out_nrm_y;  got.nrm_z = out_mon.out_nrm_z;
        got.passed_through = out_mon.passed_through;
        if (skinned_q.size() == 0) begin
          $error("result with no vertex request outstanding");
          errors++;
        end else begin
          want = skinned_q.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("out_pos_x: expected %0d, got %0d", want.pos_x, got.pos_x); errors++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("out_pos_y: expected %0d, got %0d", want.pos_y, got.pos_y); errors++;
          end
          if (got.pos_z !== want.pos_z) begin
            $error("out_pos_z: expected %0d, got %0d", want.pos_z, got.pos_z); errors++;
          end
          if (got.nrm_x !== want.nrm_x) begin
            $error("out_nrm_x: expected %0d, got %0d", want.nrm_x, got.nrm_x); errors++;
          end
          if (got.nrm_y !== want.nrm_y) begin
            $error("out_nrm_y: expected %0d, got %0d", want.nrm_y, got.nrm_y); errors++;
          end
          if (got.nrm_z !== want.nrm_z) begin
            $error("out_nrm_z: expected %0d, got %0d", want.nrm_z, got.nrm_z); errors++;
          end
          if (got.passed_through !== want.passed_through) begin
            $error("passed_through: expected %0b, got %0b",
                   want.passed_through, got.passed_through);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD) begin
          load_count++;
          if (in_mon.entry_slot < SLOTS)
            palette[in_mon.entry_bone][in_mon.entry_slot] = in_mon.entry_value;
        end else begin
          want = blend_vertex();
          vertex_count++;
          if (want.passed_through) copy_count++;
          skinned_q.push_back(want);
        end
      end
      pending = skinned_q.size();
    end
  end

endmodule

// ===== tb/tb_linear_blend_vertex_skinning.sv =====
`timescale 1ns / 100ps
// Top of the vertex skinning testbench: clock, reset, request stimulus and verdict.
module tb_linear_blend_vertex_skinning;
  import lbs_pkg::*;

  logic clk;
  logic rst_n;
  int   errors, pending, vertex_count, copy_count, load_count;

  bit [11:0] slots_written [BONES_DEF];
  int        full_bones[$];
  bit        steady_sender;

  lbs_in_if  req_if ();
  lbs_out_if res_if ();

  linear_blend_vertex_skinning dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  lbs_skin_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (req_if),
    .out_mon      (res_if),
    .errors       (errors),
    .pending      (pending),
    .vertex_count (vertex_count),
    .copy_count   (copy_count),
    .load_count   (load_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, stretches of steady ready, one long hold-off that backs the block up.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    stall = 0;
    wait (rst_n);
    for (int cyc = 0; ; cyc++) begin
      @(negedge clk);
      if (cyc == 700) begin
        res_if.ready = 1'b0;
        for (int hold = 0; hold < 250; hold++) @(negedge clk);
      end
      if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else if ((cyc / 150) % 3 == 2) begin
        res_if.ready = 1'b1;
      end else begin
        stall = pick_gap(1'b0);
        res_if.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  task automatic drive_request(input lbs_cmd_t cmd, input logic [31:0] px, py, pz,
                               input logic [15:0] nx, ny, nz, input logic [31:0] ids,
                               input logic [63:0] wts, input logic [7:0] bone,
                               input logic [3:0] slot, input logic [31:0] value);
    @(negedge clk);
    req_if.valid         = 1'b1;
    req_if.command       = cmd;
    req_if.pos_x         = px;
    req_if.pos_y         = py;
    req_if.pos_z         = pz;
    req_if.nrm_x         = nx;
    req_if.nrm_y         = ny;
    req_if.nrm_z         = nz;
    req_if.bone_ids      = ids;
    req_if.blend_weights = wts;
    req_if.entry_bone    = bone;
    req_if.entry_slot    = slot;
    req_if.entry_value   = value;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic load_element(input int bone, input int slot, input logic [31:0] value);
    drive_request(CMD_LOAD, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom), $urandom, {$urandom, $urandom}, 8'(bone), 4'(slot),
                  value);
    if (slot < SLOTS) begin
      slots_written[bone][slot] = 1'b1;
      if (&slots_written[bone] && !(bone inside {full_bones})) full_bones.push_back(bone);
    end
    idle_sender(pick_gap(steady_sender));
  endtask

  task automatic skin_vertex(input logic [31:0] px, py, pz, input logic [15:0] nx, ny, nz,
                             input logic [31:0] ids, input logic [63:0] wts);
    drive_request(CMD_SKIN, px, py, pz, nx, ny, nz, ids, wts, 8'($urandom), 4'($urandom),
                  $urandom);
    idle_sender(pick_gap(steady_sender));
  endtask

  function automatic logic [31:0] matrix_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic logic [31:0] position_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
  endfunction

  function automatic logic [31:0] full_bone_ids();
    logic [31:0] ids;
    for (int n = 0; n < 4; n++)
      ids[8*n +: 8] = 8'(full_bones[$urandom_range(0, full_bones.size() - 1)]);
    return ids;
  endfunction

  // Positive weights for a prefix of influences, then zero or negative stop weights.
  function automatic logic [63:0] blend_weights_value();
    logic [63:0] w;
    int          used;
    used = $urandom_range(1, 4);
    for (int n = 0; n < 4; n++) begin
      if (n < used)
        w[16*n +: 16] = ($urandom_range(0, 9) == 0) ? 16'h7fff :
                        16'($urandom_range(1, 32767));
      else
        w[16*n +: 16] = $urandom_range(0, 1) ? 16'h0000 :
                        16'($urandom_range(32768, 65535));
    end
    if ($urandom_range(0, 9) == 0) w[15:0] = $urandom_range(0, 1) ? 16'h0 : 16'($urandom);
    if ($urandom_range(0, 9) == 0) w[15:0] = 16'($urandom_range(32768, 65535));
    return w;
  endfunction

  initial begin
    int bones_setup[12] = '{0, 1, 2, 4, 8, 16, 32, 64, 128, 255, 85, 170};
    req_if.valid = 1'b0;
    req_if.command = CMD_SKIN;
    {req_if.pos_x, req_if.pos_y, req_if.pos_z} = '0;
    {req_if.nrm_x, req_if.nrm_y, req_if.nrm_z} = '0;
    req_if.bone_ids = '0;
    req_if.blend_weights = '0;
    req_if.entry_bone = '0;
    req_if.entry_slot = '0;
    req_if.entry_value = '0;
    steady_sender = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill a set of bones whose numbers exercise every index bit.
    foreach (bones_setup[i])
      for (int s = 0; s < SLOTS; s++)
        load_element(bones_setup[i], s, (bones_setup[i] == 255) ?
                     (s[0] ? 32'h7fffffff : 32'h80000000) : matrix_value());

    // Directed vertices: copy cases, weight extremes, stops and ignored loads.
    skin_vertex(32'h80000000, 32'h7fffffff, 32'h0, 16'h8000, 16'h7fff, 16'h0,
                32'h0, 64'h0);
    skin_vertex(32'h7fffffff, 32'h80000000, 32'h1, 16'h7fff, 16'h8000, 16'h1,
                32'h01020400, 64'h7fff7fff7fff8000);
    skin_vertex(32'h00010000, 32'h00020000, 32'hffff0000, 16'h4000, 16'hc000, 16'h2000,
                32'h00000001, 64'h000000000007fff);
    skin_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff,
                32'hff80aa55, 64'h7fff7fff7fff7fff);
    skin_vertex(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000,
                32'hffffffff, 64'h7fff7fff7fff7fff);
    skin_vertex(32'h00123456, 32'hfedcba98, 32'h00000100, 16'h1234, 16'hedcb, 16'h0100,
                32'h40201008, 64'h00017fff80004000);
    skin_vertex(32'h00100000, 32'h00100000, 32'h00100000, 16'h3fff, 16'h3fff, 16'h3fff,
                32'h020100aa, 64'h0000200040001000);
    load_element(0, 12, 32'h12345678);
    load_element(0, 15, 32'h87654321);
    load_element(1, 13, 32'hffffffff);
    skin_vertex(32'h00050000, 32'hfffb0000, 32'h00000000, 16'h4000, 16'h0, 16'hc000,
                32'h00000100, 64'h0000000040003fff);
    load_element(2, 0, 32'h00010000);
    skin_vertex(32'h00030000, 32'h00040000, 32'h00050000, 16'h1000, 16'h2000, 16'h3000,
                32'h02020202, 64'hffff000100020003);

    for (int i = 0; i < 500; i++) begin
      steady_sender = ((i / 60) % 4 == 3);
      if (i == 320) begin
        // Let the block drain completely before carrying on.
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 5) == 0)
          load_element($urandom_range(0, 255), $urandom_range(0, 15), $urandom);
        else
          load_element(full_bones[$urandom_range(0, full_bones.size() - 1)],
                       $urandom_range(0, SLOTS - 1), matrix_value());
      end else begin
        skin_vertex(position_value(), position_value(), position_value(), 16'($urandom),
                    16'($urandom), 16'($urandom), full_bone_ids(), blend_weights_value());
      end
    end

    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d vertices (%0d copied unchanged) and %0d palette loads,",
             vertex_count, copy_count, load_count);
    $display("with random stalls on both channels and %0d fully loaded bones.",
             full_bones.size());
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== linear_blend_vertex_skinning.f =====
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_if.sv
hw/rtl/lbs_ram.sv
hw/rtl/lbs_lane.sv
hw/rtl/linear_blend_vertex_skinning.sv
tb/lbs_skin_checker.sv
tb/tb_linear_blend_vertex_skinning.sv
